@@ rtl/tcce_pkg.sv @@
package tcce_pkg;

    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = ROWS * COLUMNS;
    localparam int ADDR_W  = $clog2(CELLS);

    localparam int X_W     = 7;
    localparam int Y_W     = 5;
    localparam int CHAR_W  = 8;
    localparam int NIB_W   = 4;
    localparam int ACT_W   = 3;

    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 32;
    localparam int M_USED_W = X_W + Y_W + CHAR_W + 2 * NIB_W + 1;

    localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CHAR_SPACE   = 8'd32;

    typedef enum logic [ACT_W-1:0] {
        ACT_PRINT     = 3'd0,
        ACT_BACKSPACE = 3'd1,
        ACT_HOME      = 3'd2,
        ACT_FILL_BG   = 3'd3,
        ACT_FILL_FG   = 3'd4,
        ACT_FILL_CHAR = 3'd5,
        ACT_READ      = 3'd6
    } act_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_CLEAR_CELL,
        DP_FILL_CELL,
        DP_PRINT,
        DP_HOME,
        DP_BS_START,
        DP_WALK_RD,
        DP_WALK_CHK,
        DP_READ_RD,
        DP_READ_CAP,
        DP_OUT
    } dp_op_t;

    typedef struct packed {
        act_t action;
        logic row_below;
        logic walk_again;
        logic sweep_last;
        logic out_busy;
    } dp_status_t;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [Y_W-1:0] row,
                                                    input logic [X_W-1:0] col);
        logic [ADDR_W+15:0] full;
        full = (ADDR_W + 16)'(row) * (ADDR_W + 16)'(COLUMNS) + (ADDR_W + 16)'(col);
        return full[ADDR_W-1:0];
    endfunction

endpackage

@@ rtl/tcce_ram.sv @@
module tcce_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/tcce_datapath.sv @@
module tcce_datapath (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tcce_pkg::dp_op_t             op,
    output tcce_pkg::dp_status_t         stat,
    input  logic [tcce_pkg::ACT_W-1:0]   s_tuser,
    input  logic [tcce_pkg::S_DATA_W-1:0] s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [tcce_pkg::M_DATA_W-1:0] m_tdata
);
    import tcce_pkg::*;

    act_t              action_reg;
    logic [CHAR_W-1:0] ch_reg;
    logic [NIB_W-1:0]  colour_reg;
    logic [Y_W-1:0]    rrow_reg;
    logic [X_W-1:0]    rcol_reg;

    logic [X_W-1:0]    x_reg;
    logic [Y_W-1:0]    y_reg;
    logic              phase_reg;
    logic [ADDR_W-1:0] sweep_reg;
    logic              status_reg;
    logic [CHAR_W-1:0] rd_char_reg;
    logic [CHAR_W-1:0] rd_colour_reg;
    logic              m_valid_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic [ADDR_W-1:0] ram_addr;
    logic              we_char, we_bg, we_fg;
    logic [CHAR_W-1:0] wchar;
    logic [NIB_W-1:0]  wbg, wfg;
    logic [CHAR_W-1:0] rchar;
    logic [NIB_W-1:0]  rbg, rfg;

    // Print: column wrap first, then newline or write.
    logic [X_W-1:0]    px;
    logic [Y_W-1:0]    py;
    logic [Y_W-1:0]    py_nl;
    logic              prt_below;
    logic              prt_write;

    logic              is_space, x_zero, walk_step, rewalk, erase;
    logic              row_below, read_in_range;

    always_comb begin
        if (int'(x_reg) >= COLUMNS) begin
            px = '0;
            py = (int'(y_reg) < ROWS) ? y_reg + 1'b1 : y_reg;
        end else begin
            px = x_reg;
            py = y_reg;
        end
        py_nl     = (int'(py) < ROWS) ? py + 1'b1 : py;
        prt_below = int'(py) >= ROWS;
        prt_write = (ch_reg != CHAR_NEWLINE) && !prt_below;
    end

    assign row_below     = int'(y_reg) >= ROWS;
    assign read_in_range = (int'(rrow_reg) < ROWS) && (int'(rcol_reg) < COLUMNS);
    assign is_space      = rchar == CHAR_SPACE;
    assign x_zero        = x_reg == '0;
    assign walk_step     = !x_zero && is_space;
    assign rewalk        = !phase_reg && x_zero && is_space && (y_reg != '0);
    assign erase         = !phase_reg && !walk_step && !rewalk;

    always_comb begin
        unique case (op)
            DP_CLEAR_CELL, DP_FILL_CELL: ram_addr = sweep_reg;
            DP_PRINT:                    ram_addr = cell_addr(py, px);
            DP_READ_RD:                  ram_addr = cell_addr(rrow_reg, rcol_reg);
            default:                     ram_addr = cell_addr(y_reg, x_reg);
        endcase
    end

    always_comb begin
        we_char = 1'b0;
        we_bg   = 1'b0;
        we_fg   = 1'b0;
        wchar   = ch_reg;
        wbg     = colour_reg;
        wfg     = colour_reg;
        unique case (op)
            DP_CLEAR_CELL: begin
                we_char = 1'b1;
                we_bg   = 1'b1;
                we_fg   = 1'b1;
                wchar   = '0;
                wbg     = '0;
                wfg     = '0;
            end
            DP_FILL_CELL: begin
                we_char = action_reg == ACT_FILL_CHAR;
                we_bg   = action_reg == ACT_FILL_BG;
                we_fg   = action_reg == ACT_FILL_FG;
            end
            DP_PRINT: begin
                we_char = prt_write;
            end
            DP_WALK_CHK: begin
                we_char = erase;
                wchar   = CHAR_SPACE;
            end
            default: begin
            end
        endcase
    end

    tcce_ram #(.WIDTH(CHAR_W), .DEPTH(CELLS)) u_char_ram (
        .clk   (aclk),
        .we    (we_char),
        .waddr (ram_addr),
        .wdata (wchar),
        .raddr (ram_addr),
        .rdata (rchar)
    );

    tcce_ram #(.WIDTH(NIB_W), .DEPTH(CELLS)) u_bg_ram (
        .clk   (aclk),
        .we    (we_bg),
        .waddr (ram_addr),
        .wdata (wbg),
        .raddr (ram_addr),
        .rdata (rbg)
    );

    tcce_ram #(.WIDTH(NIB_W), .DEPTH(CELLS)) u_fg_ram (
        .clk   (aclk),
        .we    (we_fg),
        .waddr (ram_addr),
        .wdata (wfg),
        .raddr (ram_addr),
        .rdata (rfg)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_reg       <= '0;
            y_reg       <= '0;
            phase_reg   <= 1'b0;
            sweep_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_tready && op != DP_OUT) begin
                m_valid_reg <= 1'b0;
            end
            unique case (op)
                DP_LOAD: begin
                    action_reg    <= act_t'(s_tuser);
                    ch_reg        <= s_tdata[7:0];
                    colour_reg    <= s_tdata[11:8];
                    rrow_reg      <= s_tdata[16:12];
                    rcol_reg      <= s_tdata[23:17];
                    status_reg    <= 1'b0;
                    rd_char_reg   <= '0;
                    rd_colour_reg <= '0;
                    sweep_reg     <= '0;
                end
                DP_CLEAR_CELL, DP_FILL_CELL: begin
                    sweep_reg <= sweep_reg + 1'b1;
                end
                DP_PRINT: begin
                    if (ch_reg == CHAR_NEWLINE) begin
                        x_reg <= '0;
                        y_reg <= py_nl;
                    end else begin
                        y_reg      <= py;
                        x_reg      <= prt_below ? px : px + 1'b1;
                        status_reg <= prt_below;
                    end
                end
                DP_HOME: begin
                    x_reg <= '0;
                    y_reg <= '0;
                end
                DP_BS_START: begin
                    phase_reg <= 1'b0;
                    if (row_below) begin
                        status_reg <= 1'b1;
                    end else if (int'(x_reg) >= COLUMNS) begin
                        x_reg <= X_W'(COLUMNS - 1);
                    end
                end
                DP_WALK_CHK: begin
                    if (walk_step) begin
                        x_reg <= x_reg - 1'b1;
                    end else if (rewalk) begin
                        // Blank row start: continue the walk from the end of the row above.
                        y_reg     <= y_reg - 1'b1;
                        x_reg     <= X_W'(COLUMNS - 1);
                        phase_reg <= 1'b1;
                    end
                end
                DP_READ_CAP: begin
                    if (read_in_range) begin
                        rd_char_reg   <= rchar;
                        rd_colour_reg <= {rbg, rfg};
                    end
                end
                DP_OUT: begin
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= {(M_DATA_W - M_USED_W)'(0), status_reg, rd_colour_reg,
                                    rd_char_reg, y_reg, x_reg};
                end
                default: begin
                end
            endcase
        end
    end

    assign stat.action     = action_reg;
    assign stat.row_below  = row_below;
    assign stat.walk_again = walk_step || rewalk;
    assign stat.sweep_last = sweep_reg == ADDR_W'(CELLS - 1);
    assign stat.out_busy   = m_valid_reg && !m_tready;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

@@ rtl/tcce_ctrl.sv @@
module tcce_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  tcce_pkg::dp_status_t stat,
    output tcce_pkg::dp_op_t     op
);
    import tcce_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DISPATCH,
        ST_FILL,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_READ_CAP,
        ST_FINISH
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        op         = DP_NOP;
        unique case (state_reg)
            ST_CLEAR: begin
                op = DP_CLEAR_CELL;
                if (stat.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    op         = DP_LOAD;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                unique case (stat.action)
                    ACT_PRINT: begin
                        op         = DP_PRINT;
                        state_next = ST_FINISH;
                    end
                    ACT_BACKSPACE: begin
                        op         = DP_BS_START;
                        state_next = stat.row_below ? ST_FINISH : ST_WALK_RD;
                    end
                    ACT_HOME: begin
                        op         = DP_HOME;
                        state_next = ST_FINISH;
                    end
                    ACT_FILL_BG, ACT_FILL_FG, ACT_FILL_CHAR: begin
                        state_next = ST_FILL;
                    end
                    ACT_READ: begin
                        op         = DP_READ_RD;
                        state_next = ST_READ_CAP;
                    end
                    default: begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_FILL: begin
                op = DP_FILL_CELL;
                if (stat.sweep_last) begin
                    state_next = ST_FINISH;
                end
            end
            ST_WALK_RD: begin
                op         = DP_WALK_RD;
                state_next = ST_WALK_CHK;
            end
            ST_WALK_CHK: begin
                op         = DP_WALK_CHK;
                state_next = stat.walk_again ? ST_WALK_RD : ST_FINISH;
            end
            ST_READ_CAP: begin
                op         = DP_READ_CAP;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                // Hold the result until the output register is free.
                if (!stat.out_busy) begin
                    op         = DP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = state_reg == ST_IDLE;

endmodule

@@ rtl/text_console_cursor_engine.sv @@
// Channel | Direction | Ports                         | Fields (lowest bit up)
// s_      | in        | s_tvalid s_tready s_tdata s_tuser | tuser: action; tdata: char_code,
//         |           |                               |   colour_value, read_row, read_column
// m_      | out       | m_tvalid m_tready m_tdata     | cursor_column, cursor_row,
//         |           |                               |   cell_character, cell_colour, status
//
// Print, home and unused actions pass through ST_DISPATCH and ST_FINISH; a read also passes
// through ST_READ_CAP, set by the registered read of the cell memories.
// Backspace passes through ST_WALK_RD and ST_WALK_CHK for every cell the walk visits (one memory read each).
// Fills sweep every cell, one cell written per cycle by the address sweep.
// After reset a clearing pass over all CELLS (2000) cells zeroes the store; s_tready is low meanwhile.
// The next item is taken while a result waits on m_; a result that cannot leave stalls the engine.
module text_console_cursor_engine (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tcce_pkg::S_DATA_W-1:0]  s_tdata,  // char_code, colour_value, read_row, read_column
    input  logic [tcce_pkg::ACT_W-1:0]     s_tuser,  // action
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tcce_pkg::M_DATA_W-1:0]  m_tdata   // cursor_column, cursor_row, cell_character,
                                                     // cell_colour, status
);
    import tcce_pkg::*;

    dp_op_t     op;
    dp_status_t stat;

    tcce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .op       (op)
    );

    tcce_datapath u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .op       (op),
        .stat     (stat),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

@@ tb/sv/text_console_cursor_engine_tb.sv @@
`timescale 1ns / 1ps

module text_console_cursor_engine_tb;

    import tcce_pkg::*;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
    localparam int RANDOM_ITEMS   = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int STALL_LIMIT    = 20000;
    localparam int MAX_REPORTS    = 50;

    // Input item as it sits in s_tdata, lowest field in the lowest bits.
    typedef struct packed {
        logic [X_W-1:0]    read_column;
        logic [Y_W-1:0]    read_row;
        logic [NIB_W-1:0]  colour_value;
        logic [CHAR_W-1:0] char_code;
    } console_cmd_t;

    // Result as it sits in m_tdata; the top bits are zero padding.
    typedef struct packed {
        logic [M_DATA_W-M_USED_W-1:0] pad;
        logic                         status;
        logic [CHAR_W-1:0]            colour;
        logic [CHAR_W-1:0]            character;
        logic [Y_W-1:0]               row;
        logic [X_W-1:0]               column;
    } console_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [ACT_W-1:0]      s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_DATA_W-1:0]   m_tdata;

    // Expected console state.
    logic [15:0]           screen [CELLS];
    logic [X_W-1:0]        cur_col;
    logic [Y_W-1:0]        cur_row;

    console_result_t       pending_results [$];
    int                    items_sent;
    int                    results_seen;
    int                    mismatch_count;
    bit                    send_idle_en;
    bit                    recv_idle_en;
    bit                    hold_request;

    text_console_cursor_engine i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Console prediction
    // ------------------------------------------------------------------

    function automatic int cell_index(input int row, input int col);
        return row * COLUMNS + col;
    endfunction

    function automatic logic [CHAR_W-1:0] glyph_at(input int row, input int col);
        return screen[cell_index(row, col)][7:0];
    endfunction

    function automatic void console_clear();
        for (int i = 0; i < CELLS; i++) begin
            screen[i] = '0;
        end
        cur_col = '0;
        cur_row = '0;
    endfunction

    function automatic void advance_row();
        if (cur_row < ROWS) begin
            cur_row++;
        end
    endfunction

    function automatic void walk_spaces_left();
        while (cur_col != 0 && glyph_at(int'(cur_row), int'(cur_col)) == CHAR_SPACE) begin
            cur_col--;
        end
    endfunction

    function automatic logic print_glyph(input logic [CHAR_W-1:0] ch);
        int idx;
        if (cur_col >= COLUMNS) begin
            cur_col = '0;
            advance_row();
        end
        if (ch == CHAR_NEWLINE) begin
            advance_row();
            cur_col = '0;
            return 1'b0;
        end
        if (cur_row >= ROWS) begin
            return 1'b1;
        end
        idx = cell_index(int'(cur_row), int'(cur_col));
        screen[idx][7:0] = ch;
        cur_col++;
        return 1'b0;
    endfunction

    function automatic logic erase_back();
        if (cur_row >= ROWS) begin
            return 1'b1;
        end
        if (cur_col >= COLUMNS) begin
            cur_col = X_W'(COLUMNS - 1);
        end
        walk_spaces_left();
        // A blank start of a row moves up to the previous row and erases nothing.
        if (cur_col == 0 && glyph_at(int'(cur_row), 0) == CHAR_SPACE && cur_row > 0) begin
            cur_row--;
            cur_col = X_W'(COLUMNS - 1);
            walk_spaces_left();
            return 1'b0;
        end
        screen[cell_index(int'(cur_row), int'(cur_col))][7:0] = CHAR_SPACE;
        return 1'b0;
    endfunction

    function automatic console_result_t console_step(input logic [ACT_W-1:0] act,
                                                     input console_cmd_t cmd);
        console_result_t res;
        logic [15:0]     cell_word;
        res = '0;
        case (act)
            ACT_PRINT: begin
                res.status = print_glyph(cmd.char_code);
            end
            ACT_BACKSPACE: begin
                res.status = erase_back();
            end
            ACT_HOME: begin
                cur_col = '0;
                cur_row = '0;
            end
            ACT_FILL_BG: begin
                for (int i = 0; i < CELLS; i++) begin
                    screen[i][15:12] = cmd.colour_value;
                end
            end
            ACT_FILL_FG: begin
                for (int i = 0; i < CELLS; i++) begin
                    screen[i][11:8] = cmd.colour_value;
                end
            end
            ACT_FILL_CHAR: begin
                for (int i = 0; i < CELLS; i++) begin
                    screen[i][7:0] = cmd.char_code;
                end
            end
            ACT_READ: begin
                if (cmd.read_row < ROWS && cmd.read_column < COLUMNS) begin
                    cell_word     = screen[cell_index(int'(cmd.read_row),
                                                      int'(cmd.read_column))];
                    res.character = cell_word[7:0];
                    res.colour    = cell_word[15:8];
                end
            end
            default: begin
            end
        endcase
        res.column = cur_col;
        res.row    = cur_row;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------

    task automatic send_item(input logic [ACT_W-1:0] act, input console_cmd_t cmd);
        int gap;
        gap = send_idle_en ? $urandom_range(0, 15) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= cmd;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(console_step(act, cmd));
        items_sent++;
    endtask

    task automatic send_print(input logic [CHAR_W-1:0] ch);
        console_cmd_t cmd;
        cmd           = console_cmd_t'($urandom);
        cmd.char_code = ch;
        send_item(ACT_PRINT, cmd);
    endtask

    task automatic send_read(input logic [Y_W-1:0] row, input logic [X_W-1:0] col);
        console_cmd_t cmd;
        cmd             = console_cmd_t'($urandom);
        cmd.read_row    = row;
        cmd.read_column = col;
        send_item(ACT_READ, cmd);
    endtask

    task automatic send_fill(input logic [ACT_W-1:0] act, input logic [CHAR_W-1:0] ch,
                             input logic [NIB_W-1:0] colour);
        console_cmd_t cmd;
        cmd              = console_cmd_t'($urandom);
        cmd.char_code    = ch;
        cmd.colour_value = colour;
        send_item(act, cmd);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    // Before each result m_tready may stay low for a random wait, or for HOLD_CYCLES when a hold-off is requested.
    initial begin
        int wait_n;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                wait_n       = HOLD_CYCLES;
                hold_request = 1'b0;
            end else begin
                wait_n = recv_idle_en ? $urandom_range(0, 15) : 0;
            end
            if (wait_n > 0) begin
                m_tready <= 1'b0;
                repeat (wait_n) @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned want,
                                   input int unsigned got);
        if (mismatch_count < MAX_REPORTS) begin
            $display("[%0t] result %0d %s: expected %0d, got %0d",
                     $realtime, results_seen, what, want, got);
        end
        mismatch_count++;
    endtask

    always @(posedge aclk) begin
        console_result_t got;
        console_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = console_result_t'(m_tdata);
            if (pending_results.size() == 0) begin
                report_mismatch("transfer with nothing pending", 0, got);
            end else begin
                want = pending_results.pop_front();
                if (got.column !== want.column)
                    report_mismatch("cursor_column", 32'(want.column), 32'(got.column));
                if (got.row !== want.row)
                    report_mismatch("cursor_row", 32'(want.row), 32'(got.row));
                if (got.character !== want.character)
                    report_mismatch("cell_character", 32'(want.character),
                                    32'(got.character));
                if (got.colour !== want.colour)
                    report_mismatch("cell_colour", 32'(want.colour), 32'(got.colour));
                if (got.status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(got.status));
                if (got.pad !== want.pad)
                    report_mismatch("padding", 32'(want.pad), 32'(got.pad));
            end
            results_seen++;
        end
    end

    // The longest quiet stretch is a fill behind the clearing pass or a hold-off.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    task automatic test_reset_clear();
        send_read(5'd0, 7'd0);
        send_read(Y_W'(ROWS - 1), X_W'(COLUMNS - 1));
    endtask

    task automatic test_print_and_erase();
        send_print(8'hFF);
        send_print(8'h00);
        send_print(CHAR_SPACE);
        send_print(CHAR_SPACE);
        send_item(ACT_BACKSPACE, console_cmd_t'($urandom));
        send_item(ACT_BACKSPACE, console_cmd_t'($urandom));
        send_read(5'd0, 7'd1);
    endtask

    task automatic test_fills_and_blank_rows();
        send_fill(ACT_FILL_BG, 8'h00, 4'hF);
        send_fill(ACT_FILL_FG, 8'hFF, 4'h0);
        send_fill(ACT_FILL_CHAR, CHAR_SPACE, 4'h5);
        send_print(CHAR_NEWLINE);
        send_print(CHAR_NEWLINE);
        // The whole screen is blank now, so this backspace climbs a row.
        send_item(ACT_BACKSPACE, console_cmd_t'($urandom));
        send_read(5'd3, 7'd40);
    endtask

    task automatic test_reads_and_unused();
        send_read(Y_W'(ROWS), 7'd0);
        send_read(5'd0, X_W'(COLUMNS));
        send_read(5'h1F, 7'h7F);
        send_item(ACT_UNUSED, console_cmd_t'('1));
        send_item(ACT_HOME, console_cmd_t'($urandom));
        send_read(5'd0, 7'd0);
    endtask

    function automatic logic [CHAR_W-1:0] pick_text_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) return CHAR_SPACE;
        if (r < 35) return CHAR_W'($urandom_range(0, 255));
        return CHAR_W'($urandom_range(33, 126));
    endfunction

    task automatic send_random_read();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            send_read(Y_W'($urandom_range(0, ROWS - 1)), X_W'($urandom_range(0, COLUMNS - 1)));
        else if (r < 90)
            send_read(cur_row, X_W'($urandom_range(0, COLUMNS - 1)));
        else
            send_read(Y_W'($urandom), X_W'($urandom));
    endtask

    task automatic test_random_traffic();
        int start;
        int kind;
        int len;
        start = items_sent;
        while (items_sent - start < RANDOM_ITEMS) begin
            // Now and then a stretch with no idling on either side.
            send_idle_en = ($urandom_range(0, 3) != 0);
            recv_idle_en = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                // A line of text; often exactly up to the end of the row.
                if (cur_col < COLUMNS && $urandom_range(0, 9) < 3)
                    len = COLUMNS - cur_col;
                else
                    len = $urandom_range(1, 120);
                repeat (len) begin
                    send_print(pick_text_char());
                    if ($urandom_range(0, 99) < 12) send_random_read();
                end
                if ($urandom_range(0, 1) == 0) send_print(CHAR_NEWLINE);
            end else if (kind < 50) begin
                repeat ($urandom_range(1, 90)) send_item(ACT_BACKSPACE, console_cmd_t'($urandom));
            end else if (kind < 60) begin
                repeat ($urandom_range(1, 30)) send_print(CHAR_NEWLINE);
            end else if (kind < 70) begin
                repeat ($urandom_range(1, 8)) send_random_read();
            end else if (kind < 76) begin
                send_item(ACT_HOME, console_cmd_t'($urandom));
            end else if (kind < 79) begin
                case ($urandom_range(0, 2))
                    0: send_fill(ACT_FILL_BG, CHAR_W'($urandom), NIB_W'($urandom));
                    1: send_fill(ACT_FILL_FG, CHAR_W'($urandom), NIB_W'($urandom));
                    default: send_fill(ACT_FILL_CHAR,
                                       ($urandom_range(0, 1) == 0) ? CHAR_SPACE
                                                                   : CHAR_W'($urandom),
                                       NIB_W'($urandom));
                endcase
            end else if (kind < 82) begin
                send_item(ACT_UNUSED, console_cmd_t'($urandom));
            end else begin
                repeat ($urandom_range(1, 5))
                    send_item(ACT_W'($urandom_range(0, 7)), console_cmd_t'($urandom));
            end
        end
        send_idle_en = 1'b1;
        recv_idle_en = 1'b1;
    endtask

    task automatic test_backpressure();
        hold_request = 1'b1;
        send_idle_en = 1'b0;
        repeat (24) begin
            if ($urandom_range(0, 1) == 0)
                send_print(pick_text_char());
            else
                send_random_read();
        end
        send_idle_en = 1'b1;
        wait_drained();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        items_sent     = 0;
        results_seen   = 0;
        mismatch_count = 0;
        send_idle_en   = 1'b1;
        recv_idle_en   = 1'b1;
        hold_request   = 1'b0;
        console_clear();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_clear();
        test_print_and_erase();
        test_fills_and_blank_rows();
        test_reads_and_unused();
        wait_drained();
        test_backpressure();
        test_random_traffic();
        wait_drained();
        test_backpressure();

        repeat (CELLS + 100) @(posedge aclk);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

@@ text_console_cursor_engine.f @@
rtl/tcce_pkg.sv
rtl/tcce_ram.sv
rtl/tcce_datapath.sv
rtl/tcce_ctrl.sv
rtl/text_console_cursor_engine.sv
tb/sv/text_console_cursor_engine_tb.sv
